### hdl/ansi_text_terminal_engine_macros.svh
// assertion macros shared by the terminal engine
`ifndef ANSI_TEXT_TERMINAL_ENGINE_MACROS_SVH
`define ANSI_TEXT_TERMINAL_ENGINE_MACROS_SVH

// property that holds in every cycle out of reset
`define ATTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition that implies a consequence in the next cycle
`define ATTE_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/atte_pkg.sv
`timescale 1ns / 1ps
package atte_pkg;

  localparam int SES_W = 3;
  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] ESC_BYTE = 8'h1B;
  localparam logic [7:0] BLANK = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR = 8'h07;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_FINAL_LO = 8'h40;
  localparam logic [7:0] CH_FINAL_HI = 8'h7E;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_HOME = 8'h48;
  localparam logic [7:0] CH_CLEAR = 8'h4A;
  localparam logic [7:0] CH_SGR = 8'h6D;
  localparam logic [7:0] CH_UP = 8'h41;
  localparam logic [7:0] CH_DOWN = 8'h42;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_LEFT = 8'h44;

  localparam logic [3:0] COUNT_MAX = 4'd15;
  localparam logic [9:0] NUM_MAX = 10'd999;
  localparam logic [3:0] FG_DEFAULT = 4'd7;
  localparam logic [9:0] SGR_BOLD = 10'd1;
  localparam logic [9:0] SGR_FG_LO = 10'd30;
  localparam logic [9:0] SGR_FG_HI = 10'd37;
  localparam logic [9:0] SGR_BG_LO = 10'd40;
  localparam logic [9:0] SGR_BG_HI = 10'd47;
  localparam logic [9:0] SGR_BRIGHT_LO = 10'd90;
  localparam logic [9:0] SGR_BRIGHT_HI = 10'd97;
  localparam logic [9:0] SGR_BRIGHT_OFS = 10'd82;

  typedef enum logic [1:0] {
    KIND_IGNORE   = 2'd0,
    KIND_READ     = 2'd1,
    KIND_READ_OOR = 2'd2,
    KIND_WRITE    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [SES_W-1:0] session;
    logic [7:0]       data;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_push_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_ctl_t;

  typedef struct packed {
    logic             ignored;
    logic             in_escape;
    logic             did_clear;
    logic             did_scroll;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [7:0]       cell_attr;
    logic [7:0]       cell_char;
  } result_t;

endpackage

### hdl/atte_front.sv
`timescale 1ns / 1ps
module atte_front #(
  parameter int SESSIONS = 6,
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [23:0]           s_tdata_i,
  input  logic                  s_tuser_i,
  input  logic                  full_i,
  input  atte_pkg::back_ctl_t   ctl_i,
  output atte_pkg::queue_push_t push_o
);

  logic [2:0] ses;
  logic [4:0] rrow;
  logic [6:0] rcol;

  assign ses  = s_tdata_i[2:0];
  assign rrow = s_tdata_i[15:11];
  assign rcol = s_tdata_i[22:16];

  assign s_tready_o = !full_i && !ctl_i.init_busy;

  always_comb begin
    push_o.valid        = s_tvalid_i && s_tready_o;
    push_o.item.session = ses;
    push_o.item.data    = s_tdata_i[10:3];
    push_o.item.row     = rrow;
    push_o.item.col     = rcol;
    if ({1'b0, ses} >= 4'(SESSIONS)) begin
      push_o.item.kind = atte_pkg::KIND_IGNORE;
    end else if (!s_tuser_i) begin
      push_o.item.kind = atte_pkg::KIND_WRITE;
    end else if ({1'b0, rrow} >= 6'(ROWS) || {1'b0, rcol} >= 8'(COLS)) begin
      push_o.item.kind = atte_pkg::KIND_READ_OOR;
    end else begin
      push_o.item.kind = atte_pkg::KIND_READ;
    end
  end

endmodule

### hdl/atte_fifo.sv
`timescale 1ns / 1ps
module atte_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  atte_pkg::queue_push_t push_i,
  output logic                  full_o,
  input  atte_pkg::back_ctl_t   ctl_i,
  output logic                  valid_o,
  output atte_pkg::item_t       item_o
);

  localparam int PW = (atte_pkg::QUEUE_DEPTH > 1) ? $clog2(atte_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(atte_pkg::QUEUE_DEPTH + 1);

  atte_pkg::item_t slot_q [atte_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign full_o  = cnt_q == CW'(atte_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = slot_q[rd_q];
  assign push    = push_i.valid && !full_o;
  assign pop     = ctl_i.pop && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(atte_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(atte_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_i.item;
    end
  end

endmodule

### hdl/atte_back.sv
`timescale 1ns / 1ps
`include "ansi_text_terminal_engine_macros.svh"
module atte_back #(
  parameter int SESSIONS = 6,
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  atte_pkg::item_t     item_i,
  output atte_pkg::back_ctl_t ctl_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [31:0]         m_tdata_o
);

  localparam int CELLS = ROWS * COLS;
  localparam int TOTAL = SESSIONS * CELLS;
  localparam int AW = $clog2(TOTAL);
  localparam int SIW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RDWAIT = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_DRAIN  = 4'b1000
  } state_e;

  state_e st_q, st_d;

  logic [4:0] row_q [SESSIONS];
  logic [4:0] row_d [SESSIONS];
  logic [6:0] col_q [SESSIONS];
  logic [6:0] col_d [SESSIONS];
  logic [3:0] fg_q [SESSIONS];
  logic [3:0] fg_d [SESSIONS];
  logic [3:0] bg_q [SESSIONS];
  logic [3:0] bg_d [SESSIONS];
  logic       act_q [SESSIONS];
  logic       act_d [SESSIONS];
  logic [3:0] ecnt_q [SESSIONS];
  logic [3:0] ecnt_d [SESSIONS];
  logic [7:0] efirst_q [SESSIONS];
  logic [7:0] efirst_d [SESSIONS];
  logic [9:0] num_q [SESSIONS];
  logic [9:0] num_d [SESSIONS];

  logic [15:0] mem_q [TOTAL];
  logic [15:0] rd_q;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0] mem_wd;

  logic          pipe_v_q, pipe_v_d, pipe_blank_q, pipe_blank_d;
  logic [AW-1:0] pipe_addr_q, pipe_addr_d;
  logic [AW-1:0] walk_base_q, walk_base_d, walk_cnt_q, walk_cnt_d;
  logic [AW-1:0] walk_last_q, walk_last_d, walk_copy_q, walk_copy_d;
  logic          walk_out_q, walk_out_d, init_q, init_d;
  logic          out_valid_q, out_valid_d;
  atte_pkg::result_t res_q, res_d;

  logic            start;
  logic [SIW-1:0]  sidx;
  logic [7:0]      b;
  logic [4:0]      r;
  logic [6:0]      c;
  logic [5:0]      nr;
  logic [7:0]      nc;
  logic [3:0]      n_cnt, n_fg, n_bg;
  logic [7:0]      n_first;
  logic [9:0]      n_num;
  logic            n_act, fin, scroll, clr, cell_we, copy_ph;
  logic [6:0]      cell_col;
  logic [7:0]      cell_ch;
  logic [13:0]     prod;

  function automatic logic [AW-1:0] cell_addr(input logic [SIW-1:0] s, input logic [4:0] rr,
                                               input logic [6:0] cc);
    cell_addr = AW'(s) * AW'(CELLS) + AW'(rr) * AW'(COLS) + AW'(cc);
  endfunction

  assign start = (st_q == ST_IDLE) && valid_i && (!out_valid_q || m_tready_i);
  assign ctl_o.pop = start;
  assign ctl_o.init_busy = init_q;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o = res_q;

  assign sidx = item_i.session[SIW-1:0];
  assign b = item_i.data;
  assign r = row_q[sidx];
  assign c = col_q[sidx];

  // effect of a written byte on the session
  always_comb begin
    nr = {1'b0, r};
    nc = {1'b0, c};
    n_act = act_q[sidx];
    n_cnt = ecnt_q[sidx];
    n_first = efirst_q[sidx];
    n_num = num_q[sidx];
    n_fg = fg_q[sidx];
    n_bg = bg_q[sidx];
    scroll = 1'b0;
    clr = 1'b0;
    cell_we = 1'b0;
    cell_ch = b;
    cell_col = c;
    fin = 1'b0;
    prod = '0;
    if (act_q[sidx]) begin
      if (ecnt_q[sidx] == '0) begin
        n_first = b;
      end
      if (ecnt_q[sidx] < atte_pkg::COUNT_MAX) begin
        n_cnt = ecnt_q[sidx] + 4'd1;
      end
      fin = b >= atte_pkg::CH_FINAL_LO && b <= atte_pkg::CH_FINAL_HI &&
            !(ecnt_q[sidx] == '0 && b == atte_pkg::CH_LBRACKET);
      if (!fin) begin
        if (ecnt_q[sidx] != '0 && b >= atte_pkg::CH_ZERO && b <= atte_pkg::CH_NINE) begin
          prod = 14'(num_q[sidx]) * 14'd10 + 14'(8'(b - atte_pkg::CH_ZERO));
          n_num = (prod > 14'(atte_pkg::NUM_MAX)) ? atte_pkg::NUM_MAX : prod[9:0];
        end
      end else begin
        n_act = 1'b0;
        case (b)
          atte_pkg::CH_HOME: begin
            if (n_cnt == 4'd2) begin
              nr = '0;
              nc = '0;
            end
          end
          atte_pkg::CH_CLEAR: begin
            if (n_cnt >= 4'd2 && n_first == atte_pkg::CH_LBRACKET) begin
              clr = 1'b1;
              nr = '0;
              nc = '0;
            end
          end
          atte_pkg::CH_SGR: begin
            if (num_q[sidx] == '0) begin
              n_fg = atte_pkg::FG_DEFAULT;
              n_bg = '0;
            end else if (num_q[sidx] >= atte_pkg::SGR_FG_LO &&
                         num_q[sidx] <= atte_pkg::SGR_FG_HI) begin
              n_fg = 4'(num_q[sidx] - atte_pkg::SGR_FG_LO);
            end else if (num_q[sidx] >= atte_pkg::SGR_BG_LO &&
                         num_q[sidx] <= atte_pkg::SGR_BG_HI) begin
              n_bg = 4'(num_q[sidx] - atte_pkg::SGR_BG_LO);
            end else if (num_q[sidx] >= atte_pkg::SGR_BRIGHT_LO &&
                         num_q[sidx] <= atte_pkg::SGR_BRIGHT_HI) begin
              n_fg = 4'(num_q[sidx] - atte_pkg::SGR_BRIGHT_OFS);
            end else if (num_q[sidx] == atte_pkg::SGR_BOLD) begin
              n_fg = fg_q[sidx] | 4'd8;
            end
          end
          atte_pkg::CH_UP: begin
            if (r != '0) nr = {1'b0, r} - 6'd1;
          end
          atte_pkg::CH_DOWN: begin
            if ({1'b0, r} < 6'(ROWS - 1)) nr = {1'b0, r} + 6'd1;
          end
          atte_pkg::CH_RIGHT: begin
            if ({1'b0, c} < 8'(COLS - 1)) nc = {1'b0, c} + 8'd1;
          end
          atte_pkg::CH_LEFT: begin
            if (c != '0) nc = {1'b0, c} - 8'd1;
          end
          default: begin
          end
        endcase
        n_cnt = '0;
        n_num = '0;
      end
    end else if (b == atte_pkg::ESC_BYTE) begin
      n_act = 1'b1;
      n_cnt = '0;
      n_first = '0;
      n_num = '0;
    end else begin
      case (b)
        atte_pkg::CH_LF: begin
          nr = {1'b0, r} + 6'd1;
          nc = '0;
        end
        atte_pkg::CH_CR: begin
          nc = '0;
        end
        atte_pkg::CH_BS: begin
          if (c != '0) begin
            nc = {1'b0, c} - 8'd1;
            cell_col = c - 7'd1;
            cell_ch = atte_pkg::BLANK;
            cell_we = 1'b1;
          end
        end
        atte_pkg::CH_TAB: begin
          nc = ({1'b0, c} + 8'd8) & ~8'd7;
          if (nc >= 8'(COLS)) begin
            nc = '0;
            nr = {1'b0, r} + 6'd1;
          end
        end
        default: begin
          if (b >= atte_pkg::CH_PRINT_LO && !b[7]) begin
            cell_we = 1'b1;
            nc = {1'b0, c} + 8'd1;
            if (nc >= 8'(COLS)) begin
              nc = '0;
              nr = {1'b0, r} + 6'd1;
            end
          end
        end
      endcase
      if (nr >= 6'(ROWS)) begin
        scroll = 1'b1;
        nr = 6'(ROWS - 1);
      end
    end
  end

  always_comb begin
    st_d = st_q;
    row_d = row_q;
    col_d = col_q;
    fg_d = fg_q;
    bg_d = bg_q;
    act_d = act_q;
    ecnt_d = ecnt_q;
    efirst_d = efirst_q;
    num_d = num_q;
    pipe_v_d = 1'b0;
    pipe_blank_d = pipe_blank_q;
    pipe_addr_d = pipe_addr_q;
    walk_base_d = walk_base_q;
    walk_cnt_d = walk_cnt_q;
    walk_last_d = walk_last_q;
    walk_copy_d = walk_copy_q;
    walk_out_d = walk_out_q;
    init_d = init_q;
    res_d = res_q;
    out_valid_d = out_valid_q && !m_tready_i;
    rd_en = 1'b0;
    rd_addr = cell_addr(sidx, item_i.row, item_i.col);
    copy_ph = 1'b0;
    mem_we = 1'b0;
    mem_wa = cell_addr(sidx, r, cell_col);
    mem_wd = {bg_q[sidx], fg_q[sidx], cell_ch};

    case (st_q)
      ST_IDLE: begin
        if (start) begin
          res_d = '0;
          res_d.cur_row = r;
          res_d.cur_col = c;
          res_d.in_escape = act_q[sidx];
          case (item_i.kind)
            atte_pkg::KIND_IGNORE: begin
              res_d = '0;
              res_d.ignored = 1'b1;
              out_valid_d = 1'b1;
            end
            atte_pkg::KIND_READ_OOR: begin
              out_valid_d = 1'b1;
            end
            atte_pkg::KIND_READ: begin
              rd_en = 1'b1;
              st_d = ST_RDWAIT;
            end
            atte_pkg::KIND_WRITE: begin
              row_d[sidx] = nr[4:0];
              col_d[sidx] = nc[6:0];
              fg_d[sidx] = n_fg;
              bg_d[sidx] = n_bg;
              act_d[sidx] = n_act;
              ecnt_d[sidx] = n_cnt;
              efirst_d[sidx] = n_first;
              num_d[sidx] = n_num;
              res_d.cur_row = nr[4:0];
              res_d.cur_col = nc[6:0];
              res_d.in_escape = n_act;
              res_d.did_scroll = scroll;
              res_d.did_clear = clr;
              mem_we = cell_we;
              walk_base_d = cell_addr(sidx, '0, '0);
              walk_cnt_d = '0;
              walk_last_d = AW'(CELLS - 1);
              walk_copy_d = scroll ? AW'((ROWS - 1) * COLS) : '0;
              walk_out_d = 1'b1;
              if (scroll || clr) begin
                st_d = ST_WALK;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        res_d.cell_char = rd_q[7:0];
        res_d.cell_attr = rd_q[15:8];
        out_valid_d = 1'b1;
        st_d = ST_IDLE;
      end
      ST_WALK: begin
        copy_ph = walk_cnt_q < walk_copy_q;
        rd_en = copy_ph;
        rd_addr = walk_base_q + walk_cnt_q + AW'(COLS);
        pipe_v_d = 1'b1;
        pipe_addr_d = walk_base_q + walk_cnt_q;
        pipe_blank_d = !copy_ph;
        if (walk_cnt_q == walk_last_q) begin
          st_d = ST_DRAIN;
        end else begin
          walk_cnt_d = walk_cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (walk_out_q) out_valid_d = 1'b1;
        init_d = 1'b0;
        st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (pipe_v_q) begin
      mem_we = 1'b1;
      mem_wa = pipe_addr_q;
      mem_wd = pipe_blank_q ? {atte_pkg::DEFAULT_ATTR, atte_pkg::BLANK} : rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_WALK;
      for (int i = 0; i < SESSIONS; i++) begin
        row_q[i] <= '0;
        col_q[i] <= '0;
        fg_q[i] <= atte_pkg::FG_DEFAULT;
        bg_q[i] <= '0;
        act_q[i] <= 1'b0;
        ecnt_q[i] <= '0;
        efirst_q[i] <= '0;
        num_q[i] <= '0;
      end
      pipe_v_q <= 1'b0;
      walk_base_q <= '0;
      walk_cnt_q <= '0;
      walk_last_q <= AW'(TOTAL - 1);
      walk_copy_q <= '0;
      walk_out_q <= 1'b0;
      init_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      row_q <= row_d;
      col_q <= col_d;
      fg_q <= fg_d;
      bg_q <= bg_d;
      act_q <= act_d;
      ecnt_q <= ecnt_d;
      efirst_q <= efirst_d;
      num_q <= num_d;
      pipe_v_q <= pipe_v_d;
      walk_base_q <= walk_base_d;
      walk_cnt_q <= walk_cnt_d;
      walk_last_q <= walk_last_d;
      walk_copy_q <= walk_copy_d;
      walk_out_q <= walk_out_d;
      init_q <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_addr_q <= pipe_addr_d;
    pipe_blank_q <= pipe_blank_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  `ATTE_ASSERT(a_init_no_out, init_q |-> !out_valid_q)
  `ATTE_ASSERT(a_one_writer, !(pipe_v_q && start))
  `ATTE_ASSERT(a_walk_bound, (st_q == ST_WALK) |-> (walk_cnt_q <= walk_last_q))
  `ATTE_ASSERT_NEXT(a_walk_to_drain, (st_q == ST_WALK) && (walk_cnt_q == walk_last_q),
                    pipe_v_q && (st_q == ST_DRAIN))

endmodule

### hdl/ansi_text_terminal_engine.sv
`timescale 1ns / 1ps
// Multi-session text terminal: each session owns a character/attribute screen, a
// cursor, colors and an escape parser; all screens share one cell memory.
// Input channel s_*: one transfer is a byte write (tuser 0) or a cell read (tuser 1).
// Output channel m_*: exactly one result transfer per input transfer, in order.
// Accepted items pass through a two-entry queue to the executing back end.
// With the back end free, writes that neither scroll nor clear, ignored items and out-of-range
// reads go from the queue head straight into the output register; in-range reads pass through
// ST_RDWAIT first (registered memory read). The back end takes a new item only in ST_IDLE and
// only while the output register is empty or being taken. A scroll walks the session screen
// (row copy through the read port, then the bottom row blanked); an ESC [ J clear walks the
// whole session screen too, blanking it. Reset: the whole memory is swept to spaces/0x07,
// with s_tready_o low throughout.
// When the receiver stalls the result holds in the output register; the queue
// keeps taking input until it fills, then s_tready_o drops.
module ansi_text_terminal_engine #(
  parameter int SESSIONS = 6,
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // session[2:0], byte_in[10:3], read_row[15:11], read_col[22:16]
  input  logic        s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // cell_char, cell_attr, cur_row, cur_col, did_scroll,
                                // did_clear, in_escape, ignored
);

  atte_pkg::queue_push_t push;
  atte_pkg::back_ctl_t   ctl;
  atte_pkg::item_t       item;
  logic                  full, valid;

  atte_front #(.SESSIONS(SESSIONS), .ROWS(ROWS), .COLS(COLS)) u_front (
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .full_i     (full),
    .ctl_i      (ctl),
    .push_o     (push)
  );

  atte_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .ctl_i   (ctl),
    .valid_o (valid),
    .item_o  (item)
  );

  atte_back #(.SESSIONS(SESSIONS), .ROWS(ROWS), .COLS(COLS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid),
    .item_i     (item),
    .ctl_o      (ctl),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int NSES = 6;
  localparam int NROW = 25;
  localparam int NCOL = 80;
  localparam int WDOG_LIMIT = 60000;

  typedef struct {
    logic [7:0] ch;
    logic [7:0] at;
    logic [4:0] row;
    logic [6:0] col;
    logic       scr;
    logic       clr;
    logic       esc;
    logic       ign;
  } term_res_t;

  typedef struct {
    bit         rd;
    bit [2:0]   ses;
    bit [7:0]   data;
    bit [4:0]   row;
    bit [6:0]   col;
    bit         has_exp;
    bit [31:0]  exp_word;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  ansi_text_terminal_engine #(.SESSIONS(NSES), .ROWS(NROW), .COLS(NCOL)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk_i = ~clk_i;

  // terminal mirror
  logic [7:0] scr_char [NSES][NROW][NCOL];
  logic [7:0] scr_attr [NSES][NROW][NCOL];
  logic [4:0] crow [NSES];
  logic [6:0] ccol [NSES];
  logic [3:0] fg [NSES];
  logic [3:0] bg [NSES];
  logic       esc_on [NSES];
  logic [3:0] esc_cnt [NSES];
  logic [7:0] esc_lead [NSES];
  logic [9:0] sgr_val [NSES];

  term_res_t  pending_results [$];
  int         errors = 0;
  int         n_sent = 0;
  int         n_got = 0;
  int         n_scroll = 0;
  int         n_clear = 0;
  int         send_idle = 12;
  int         recv_idle = 84;
  int         quiet = 0;

  function automatic logic [31:0] pack_res(term_res_t r);
    atte_pkg::result_t p;
    p.cell_char = r.ch; p.cell_attr = r.at; p.cur_row = r.row; p.cur_col = r.col;
    p.did_scroll = r.scr; p.did_clear = r.clr; p.in_escape = r.esc; p.ignored = r.ign;
    return p;
  endfunction

  task automatic term_reset();
    for (int s = 0; s < NSES; s++) begin
      for (int r = 0; r < NROW; r++)
        for (int c = 0; c < NCOL; c++) begin
          scr_char[s][r][c] = atte_pkg::BLANK;
          scr_attr[s][r][c] = atte_pkg::DEFAULT_ATTR;
        end
      crow[s] = '0; ccol[s] = '0; fg[s] = atte_pkg::FG_DEFAULT; bg[s] = '0;
      esc_on[s] = 1'b0; esc_cnt[s] = '0; esc_lead[s] = '0; sgr_val[s] = '0;
    end
  endtask

  function automatic void scroll_up(int s);
    for (int r = 0; r < NROW - 1; r++)
      for (int c = 0; c < NCOL; c++) begin
        scr_char[s][r][c] = scr_char[s][r+1][c];
        scr_attr[s][r][c] = scr_attr[s][r+1][c];
      end
    for (int c = 0; c < NCOL; c++) begin
      scr_char[s][NROW-1][c] = atte_pkg::BLANK;
      scr_attr[s][NROW-1][c] = atte_pkg::DEFAULT_ATTR;
    end
  endfunction

  function automatic void escape_step(int s, logic [7:0] b, output logic cleared);
    int pos;
    int n;
    pos = esc_cnt[s];
    cleared = 1'b0;
    if (pos == 0) esc_lead[s] = b;
    if (pos < atte_pkg::COUNT_MAX) esc_cnt[s] = 4'(pos + 1);
    if (!(b >= atte_pkg::CH_FINAL_LO && b <= atte_pkg::CH_FINAL_HI) ||
        (pos == 0 && b == atte_pkg::CH_LBRACKET)) begin
      if (pos >= 1 && b >= atte_pkg::CH_ZERO && b <= atte_pkg::CH_NINE) begin
        n = sgr_val[s] * 10 + (b - atte_pkg::CH_ZERO);
        sgr_val[s] = (n > atte_pkg::NUM_MAX) ? atte_pkg::NUM_MAX : 10'(n);
      end
      return;
    end
    esc_on[s] = 1'b0;
    if (b == atte_pkg::CH_HOME && esc_cnt[s] == 2) begin
      crow[s] = '0; ccol[s] = '0;
    end else if (b == atte_pkg::CH_CLEAR && esc_cnt[s] >= 2 &&
                 esc_lead[s] == atte_pkg::CH_LBRACKET) begin
      for (int r = 0; r < NROW; r++)
        for (int c = 0; c < NCOL; c++) begin
          scr_char[s][r][c] = atte_pkg::BLANK;
          scr_attr[s][r][c] = atte_pkg::DEFAULT_ATTR;
        end
      crow[s] = '0; ccol[s] = '0;
      cleared = 1'b1;
    end else if (b == atte_pkg::CH_SGR) begin
      n = sgr_val[s];
      if (n == 0) begin
        fg[s] = atte_pkg::FG_DEFAULT; bg[s] = '0;
      end else if (n >= atte_pkg::SGR_FG_LO && n <= atte_pkg::SGR_FG_HI)
        fg[s] = 4'(n - atte_pkg::SGR_FG_LO);
      else if (n >= atte_pkg::SGR_BG_LO && n <= atte_pkg::SGR_BG_HI)
        bg[s] = 4'(n - atte_pkg::SGR_BG_LO);
      else if (n >= atte_pkg::SGR_BRIGHT_LO && n <= atte_pkg::SGR_BRIGHT_HI)
        fg[s] = 4'(n - atte_pkg::SGR_BRIGHT_OFS);
      else if (n == atte_pkg::SGR_BOLD) fg[s] = fg[s] | 4'h8;
    end else if (b == atte_pkg::CH_UP) begin
      if (crow[s] > 0) crow[s]--;
    end else if (b == atte_pkg::CH_DOWN) begin
      if (crow[s] < NROW - 1) crow[s]++;
    end else if (b == atte_pkg::CH_RIGHT) begin
      if (ccol[s] < NCOL - 1) ccol[s]++;
    end else if (b == atte_pkg::CH_LEFT) begin
      if (ccol[s] > 0) ccol[s]--;
    end
    esc_cnt[s] = '0;
    sgr_val[s] = '0;
  endfunction

  function automatic void plain_step(int s, logic [7:0] b, output logic scrolled);
    int r;
    int c;
    r = crow[s];
    c = ccol[s];
    scrolled = 1'b0;
    if (b == atte_pkg::CH_BS) begin
      if (c > 0) begin
        c--;
        scr_char[s][r][c] = atte_pkg::BLANK;
        scr_attr[s][r][c] = {bg[s], fg[s]};
        ccol[s] = 7'(c);
      end
      return;
    end
    if (b == atte_pkg::CH_LF) begin
      r++; c = 0;
    end else if (b == atte_pkg::CH_CR) c = 0;
    else if (b == atte_pkg::CH_TAB) begin
      c = (c + 8) & ~7;
      if (c >= NCOL) begin
        c = 0; r++;
      end
    end else if (b >= atte_pkg::CH_PRINT_LO && b < 8'h80) begin
      scr_char[s][r][c] = b;
      scr_attr[s][r][c] = {bg[s], fg[s]};
      c++;
      if (c >= NCOL) begin
        c = 0; r++;
      end
    end
    if (r >= NROW) begin
      scroll_up(s);
      r = NROW - 1;
      scrolled = 1'b1;
    end
    crow[s] = 5'(r);
    ccol[s] = 7'(c);
  endfunction

  function automatic term_res_t term_step(bit rd, int s, logic [7:0] b, int rr, int rc);
    term_res_t o;
    o = '{default: '0};
    if (s >= NSES) begin
      o.ign = 1'b1;
      return o;
    end
    if (rd) begin
      if (rr < NROW && rc < NCOL) begin
        o.ch = scr_char[s][rr][rc];
        o.at = scr_attr[s][rr][rc];
      end
    end else if (esc_on[s]) escape_step(s, b, o.clr);
    else if (b == atte_pkg::ESC_BYTE) begin
      esc_on[s] = 1'b1; esc_cnt[s] = '0; esc_lead[s] = '0; sgr_val[s] = '0;
    end else plain_step(s, b, o.scr);
    o.row = crow[s];
    o.col = ccol[s];
    o.esc = esc_on[s];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_got);
  endtask

  // one transfer into the block; the expected result is queued at acceptance
  task automatic put_item(bit rd, bit [2:0] ses, bit [7:0] b, bit [4:0] rr, bit [6:0] rc,
                          bit has_exp = 0, bit [31:0] exp_word = 0);
    term_res_t e;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rd;
    s_tdata  <= {1'b0, rc, rr, b, ses};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    e = term_step(rd, ses, b, rr, rc);
    if (has_exp && pack_res(e) != exp_word)
      report_mismatch("directed row", pack_res(e), exp_word);
    pending_results.push_back(e);
    n_sent++;
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_bytes(bit [2:0] ses, string str);
    for (int i = 0; i < str.len(); i++) put_item(0, ses, str[i], 0, 0);
  endtask

  always @(posedge clk_i) begin
    term_res_t e;
    logic [31:0] w;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        quiet <= 0;
        n_got++;
        if (pending_results.size() == 0) report_mismatch("unexpected result", m_tdata, 0);
        else begin
          e = pending_results.pop_front();
          w = pack_res(e);
          if (e.scr) n_scroll++;
          if (e.clr) n_clear++;
          if (m_tdata[7:0] != w[7:0]) report_mismatch("cell_char", m_tdata, w);
          if (m_tdata[15:8] != w[15:8]) report_mismatch("cell_attr", m_tdata, w);
          if (m_tdata[20:16] != w[20:16]) report_mismatch("cur_row", m_tdata, w);
          if (m_tdata[27:21] != w[27:21]) report_mismatch("cur_col", m_tdata, w);
          if (m_tdata[31:28] != w[31:28]) report_mismatch("flags", m_tdata, w);
        end
      end else if (s_tvalid && s_tready) quiet <= 0;
      else quiet <= quiet + 1;
      m_tready <= ($urandom_range(99) >= recv_idle);
      if (quiet >= WDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  stim_row_t stim_table [$];

  task automatic add_row(bit rd, bit [2:0] ses, bit [7:0] b, bit [4:0] rr, bit [6:0] rc,
                         bit has_exp = 0, bit [31:0] w = 0);
    stim_row_t t;
    t.rd = rd; t.ses = ses; t.data = b; t.row = rr; t.col = rc;
    t.has_exp = has_exp; t.exp_word = w;
    stim_table.push_back(t);
  endtask

  task automatic random_phase(int count);
    int k;
    int pick;
    bit [2:0] s;
    k = 0;
    while (k < count) begin
      s = 3'($urandom_range(5));
      pick = $urandom_range(99);
      if (pick < 30) begin
        put_item(0, s, 8'($urandom_range(8'h20, 8'h7e)), 0, 0); k++;
      end else if (pick < 45) begin
        put_item(1, s, 8'($urandom), 5'($urandom_range(24)), 7'($urandom_range(79))); k++;
      end else if (pick < 50) begin
        put_item(1, 3'($urandom), 8'($urandom), 5'($urandom), 7'($urandom)); k++;
      end else if (pick < 60) begin
        put_item(0, s, 8'($urandom), 5'($urandom), 7'($urandom)); k++;
      end else if (pick < 70) begin
        case ($urandom_range(3))
          0: put_item(0, s, atte_pkg::CH_LF, 0, 0);
          1: put_item(0, s, atte_pkg::CH_TAB, 0, 0);
          2: put_item(0, s, atte_pkg::CH_BS, 0, 0);
          default: put_item(0, s, atte_pkg::CH_CR, 0, 0);
        endcase
        k++;
      end else begin
        // escape sequence with random content
        put_item(0, s, atte_pkg::ESC_BYTE, 0, 0); k++;
        if ($urandom_range(3) != 0) begin
          put_item(0, s, atte_pkg::CH_LBRACKET, 0, 0); k++;
        end
        repeat ($urandom_range(4)) begin
          put_item(0, s, ($urandom_range(9) == 0) ? 8'h3b :
                   8'(atte_pkg::CH_ZERO + $urandom_range(9)), 0, 0);
          k++;
        end
        case ($urandom_range(9))
          0: put_item(0, s, atte_pkg::CH_HOME, 0, 0);
          1: put_item(0, s, ($urandom_range(3) == 0) ? atte_pkg::CH_CLEAR : atte_pkg::CH_SGR,
                      0, 0);
          2, 3: put_item(0, s, atte_pkg::CH_SGR, 0, 0);
          4: put_item(0, s, atte_pkg::CH_UP, 0, 0);
          5: put_item(0, s, atte_pkg::CH_DOWN, 0, 0);
          6: put_item(0, s, atte_pkg::CH_RIGHT, 0, 0);
          7: put_item(0, s, atte_pkg::CH_LEFT, 0, 0);
          default: put_item(0, s, 8'($urandom), 0, 0);
        endcase
        k++;
      end
    end
  endtask

  initial begin
    term_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_row(1, 0, 8'h00, 0, 0, 1, 32'h0000_0720);
    add_row(1, 5, 8'hff, 24, 79, 1, 32'h0000_0720);
    add_row(1, 3, 8'h00, 25, 0, 1, 32'h0);
    add_row(1, 3, 8'h00, 31, 127, 1, 32'h0);
    add_row(0, 6, 8'h41, 0, 0, 1, 32'h8000_0000);
    add_row(1, 7, 8'hff, 31, 127, 1, 32'h8000_0000);
    add_row(0, 0, 8'h41, 0, 0);
    add_row(0, 0, 8'h80, 0, 0);
    add_row(0, 0, 8'hff, 31, 127);
    add_row(0, 0, atte_pkg::CH_TAB, 0, 0);
    add_row(0, 0, atte_pkg::CH_BS, 0, 0);
    add_row(0, 0, atte_pkg::CH_CR, 0, 0);
    add_row(0, 0, atte_pkg::CH_BS, 0, 0);
    add_row(0, 0, atte_pkg::CH_LF, 0, 0);
    add_row(0, 0, 8'h01, 0, 0);
    add_row(0, 0, atte_pkg::ESC_BYTE, 0, 0);
    add_row(0, 0, atte_pkg::CH_LBRACKET, 0, 0);
    add_row(0, 0, atte_pkg::CH_LBRACKET, 0, 0);
    add_row(0, 0, atte_pkg::CH_HOME, 0, 0);
    add_row(1, 0, 8'h00, 0, 0);
    add_row(1, 0, 8'h00, 1, 0);
    foreach (stim_table[i])
      put_item(stim_table[i].rd, stim_table[i].ses, stim_table[i].data, stim_table[i].row,
               stim_table[i].col, stim_table[i].has_exp, stim_table[i].exp_word);

    // color codes, saturation, bold, cursor edges, clear, tab wrap and scrolls
    put_bytes(1, "\033[31m\033[44mX\033[1mY\033[97mZ\033[0mW\033[12345m\033[1m\033[m");
    put_bytes(1, "\033[A\033[D\033[H\033H\033[2J\033J\033[J");
    for (int i = 0; i < 30; i++) put_bytes(1, "\033[B\033[C\033[C\033[C");
    put_bytes(1, "\033[C\033[B\033x\033[;5H\033[0;999;7");
    put_bytes(1, "ab\t\t\t\t\t\t\t\t\t\t");
    for (int i = 0; i < 26; i++) put_item(0, 2, atte_pkg::CH_LF, 0, 0);
    for (int i = 0; i < 82; i++) put_item(0, 2, 8'h7e, 0, 0);
    put_item(1, 2, 0, 24, 0);
    put_item(1, 2, 0, 24, 79);
    put_item(1, 2, 0, 23, 79);
    wait_drain();

    random_phase(90);
    wait_drain();
    send_idle = 84;
    recv_idle = 12;
    random_phase(90);
    wait_drain();
    send_idle = 0;
    recv_idle = 0;
    random_phase(90);
    wait_drain();
    repeat (20) @(posedge clk_i);

    $display("sent %0d items, checked %0d results (%0d scrolls, %0d clears)",
             n_sent, n_got, n_scroll, n_clear);
    $display("covered writes, escape sequences, reads and ignored sessions under idling");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
